// ----- rtl/apcf_pkg.sv -----
// Shared types and constants of the adjacent particle Coulomb force unit.
`default_nettype none

package apcf_pkg;

  localparam int unsigned COORD_WIDTH = 16;
  localparam int unsigned FORCE_W     = 48;
  localparam int unsigned DIST_W      = 33;
  localparam int unsigned INDEX_W     = 16;
  localparam int unsigned SQ_W        = 2 * COORD_WIDTH;
  localparam int unsigned SUM_W       = SQ_W + 1;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam logic [FORCE_W-1:0] FORCE_RESET = FORCE_W'(65536);

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] pos_x;
    logic signed [COORD_WIDTH-1:0] pos_y;
    logic                          last_in_run;
  } in_word_t;

  typedef struct packed {
    logic [INDEX_W-1:0] particle_index;
    logic               neighbour_is_next;
    logic [DIST_W-1:0]  dist_squared;
    logic [FORCE_W-1:0] force_res;
    logic               zero_distance;
    logic               no_neighbour;
    logic               last_result;
  } out_word_t;

  typedef struct packed {
    logic [INDEX_W-1:0] index;
    logic               take_next;
    logic [SUM_W-1:0]   dist_sq;
    logic               last;
    logic               lone;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

  typedef enum logic [2:0] {
    F_IDLE,
    F_SQUARE,
    F_SUM,
    F_PUSH_HELD,
    F_PUSH_LAST,
    F_PUSH_LONE
  } front_state_e;

  typedef enum logic [1:0] {
    B_IDLE,
    B_DIV,
    B_DONE
  } back_state_e;

endpackage

`default_nettype wire

// ----- rtl/apcf_front.sv -----
// Front end: takes particle words, measures distances and queues result jobs.
`default_nettype none

module apcf_front (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    in_valid_i,
  output logic                   in_stall_o,
  input  apcf_pkg::in_word_t     in_word_i,
  input  apcf_pkg::queue_stat_t  q_stat_i,
  output logic                   push_o,
  output apcf_pkg::job_t         job_o
);
  import apcf_pkg::*;

  front_state_e state_q, state_d;

  logic signed [COORD_WIDTH-1:0] held_x_q, held_y_q, cur_x_q, cur_y_q;
  logic [COORD_WIDTH-1:0]        absdx_q, absdy_q;
  logic [SQ_W-1:0]               sqx_q, sqy_q;
  logic [SUM_W-1:0]              fwd_q, back_dist_q;
  logic [1:0]                    seen_q;
  logic [INDEX_W-1:0]            index_q;
  logic                          cur_last_q;

  logic                          accept;
  logic [COORD_WIDTH:0]          dx, dy, negx, negy;
  logic [COORD_WIDTH-1:0]        absdx_d, absdy_d;
  logic                          take_next;

  assign accept = in_valid_i && (state_q == F_IDLE);

  always_comb begin
    dx      = {in_word_i.pos_x[COORD_WIDTH-1], in_word_i.pos_x}
            - {held_x_q[COORD_WIDTH-1], held_x_q};
    dy      = {in_word_i.pos_y[COORD_WIDTH-1], in_word_i.pos_y}
            - {held_y_q[COORD_WIDTH-1], held_y_q};
    negx    = ~dx + 1'b1;
    negy    = ~dy + 1'b1;
    absdx_d = dx[COORD_WIDTH] ? negx[COORD_WIDTH-1:0] : dx[COORD_WIDTH-1:0];
    absdy_d = dy[COORD_WIDTH] ? negy[COORD_WIDTH-1:0] : dy[COORD_WIDTH-1:0];
  end

  assign take_next = (seen_q == 2'd1) || !(back_dist_q < fwd_q);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      F_IDLE: begin
        if (accept) begin
          if (seen_q == 2'd0) begin
            state_d = in_word_i.last_in_run ? F_PUSH_LONE : F_IDLE;
          end else begin
            state_d = F_SQUARE;
          end
        end
      end
      F_SQUARE: state_d = F_SUM;
      F_SUM:    state_d = F_PUSH_HELD;
      F_PUSH_HELD: begin
        if (!q_stat_i.full) begin
          state_d = cur_last_q ? F_PUSH_LAST : F_IDLE;
        end
      end
      F_PUSH_LAST, F_PUSH_LONE: begin
        if (!q_stat_i.full) begin
          state_d = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o = (state_q != F_IDLE);
    push_o     = 1'b0;
    job_o      = '0;
    unique case (state_q)
      F_PUSH_HELD: begin
        push_o          = !q_stat_i.full;
        job_o.index     = index_q;
        job_o.take_next = take_next;
        job_o.dist_sq   = take_next ? fwd_q : back_dist_q;
      end
      F_PUSH_LAST: begin
        push_o        = !q_stat_i.full;
        job_o.index   = index_q + 1'b1;
        job_o.dist_sq = fwd_q;
        job_o.last    = 1'b1;
      end
      F_PUSH_LONE: begin
        push_o     = !q_stat_i.full;
        job_o.last = 1'b1;
        job_o.lone = 1'b1;
      end
      default: begin
        push_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= F_IDLE;
      seen_q      <= 2'd0;
      index_q     <= '0;
      held_x_q    <= '0;
      held_y_q    <= '0;
      back_dist_q <= '0;
    end else begin
      state_q <= state_d;
      if (accept && (seen_q == 2'd0) && !in_word_i.last_in_run) begin
        held_x_q <= in_word_i.pos_x;
        held_y_q <= in_word_i.pos_y;
        index_q  <= '0;
        seen_q   <= 2'd1;
      end
      if ((state_q == F_PUSH_HELD) && !q_stat_i.full && !cur_last_q) begin
        held_x_q    <= cur_x_q;
        held_y_q    <= cur_y_q;
        back_dist_q <= fwd_q;
        index_q     <= index_q + 1'b1;
        seen_q      <= 2'd2;
      end
      if ((state_q == F_PUSH_LAST) && !q_stat_i.full) begin
        held_x_q    <= '0;
        held_y_q    <= '0;
        back_dist_q <= '0;
        index_q     <= '0;
        seen_q      <= 2'd0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cur_x_q    <= in_word_i.pos_x;
      cur_y_q    <= in_word_i.pos_y;
      cur_last_q <= in_word_i.last_in_run;
      absdx_q    <= absdx_d;
      absdy_q    <= absdy_d;
    end
    if (state_q == F_SQUARE) begin
      sqx_q <= SQ_W'(absdx_q) * SQ_W'(absdx_q);
      sqy_q <= SQ_W'(absdy_q) * SQ_W'(absdy_q);
    end
    if (state_q == F_SUM) begin
      fwd_q <= SUM_W'(sqx_q) + SUM_W'(sqy_q);
    end
  end

endmodule

`default_nettype wire

// ----- rtl/apcf_queue.sv -----
// Short job queue between the front end and the divider back end.
`default_nettype none

module apcf_queue (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    push_i,
  input  apcf_pkg::job_t         job_i,
  input  wire                    pop_i,
  output apcf_pkg::job_t         job_o,
  output apcf_pkg::queue_stat_t  stat_o
);
  import apcf_pkg::*;

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  job_t             entry_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign stat_o.full  = (count_q == CNT_W'(QUEUE_DEPTH));
  assign stat_o.empty = (count_q == '0);
  assign job_o        = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ptr_inc(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= ptr_inc(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/apcf_back.sv -----
// Back end: radix-2 force divider and the output register.
`default_nettype none

module apcf_back (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire [apcf_pkg::FORCE_W-1:0]  force_constant_i,
  input  apcf_pkg::queue_stat_t        q_stat_i,
  input  apcf_pkg::job_t               job_i,
  output logic                         pop_o,
  output logic                         out_valid_o,
  input  wire                          out_stall_i,
  output apcf_pkg::out_word_t          out_word_o
);
  import apcf_pkg::*;

  localparam int unsigned CNT_W = $clog2(FORCE_W);

  back_state_e state_q, state_d;

  job_t               job_q;
  logic [SUM_W:0]     rem_q;
  logic [FORCE_W-1:0] quo_q;
  logic [CNT_W-1:0]   cnt_q;
  logic               out_valid_q;
  out_word_t          out_q;

  logic               special;
  logic [SUM_W:0]     shifted, divisor_ext;
  logic               ge;
  logic               load;
  out_word_t          result;

  assign special     = job_i.lone || (job_i.dist_sq == '0);
  assign shifted     = {rem_q[SUM_W-1:0], quo_q[FORCE_W-1]};
  assign divisor_ext = {1'b0, job_q.dist_sq};
  assign ge          = (shifted >= divisor_ext);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      B_IDLE: begin
        if (!q_stat_i.empty) begin
          state_d = special ? B_DONE : B_DIV;
        end
      end
      B_DIV: begin
        if (cnt_q == '0) begin
          state_d = B_DONE;
        end
      end
      B_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          state_d = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_comb begin
    pop_o = 1'b0;
    load  = 1'b0;
    unique case (state_q)
      B_IDLE:  pop_o = !q_stat_i.empty;
      B_DONE:  load  = !out_valid_q || !out_stall_i;
      default: pop_o = 1'b0;
    endcase
  end

  always_comb begin
    result                   = '0;
    result.particle_index    = job_q.index;
    result.neighbour_is_next = job_q.take_next;
    result.dist_squared      = DIST_W'(job_q.dist_sq);
    result.last_result       = job_q.last;
    if (job_q.lone) begin
      result.no_neighbour = 1'b1;
    end else if (job_q.dist_sq == '0) begin
      result.zero_distance = 1'b1;
      result.force_res     = '1;
    end else begin
      result.force_res = quo_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      job_q <= job_i;
      rem_q <= '0;
      quo_q <= force_constant_i;
      cnt_q <= CNT_W'(FORCE_W - 1);
    end
    if (state_q == B_DIV) begin
      rem_q <= ge ? (shifted - divisor_ext) : shifted;
      quo_q <= {quo_q[FORCE_W-2:0], ge};
      cnt_q <= cnt_q - 1'b1;
    end
    if (load) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  a_div_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_DIV && cnt_q != '0) |=>
      (state_q == B_DIV && cnt_q == $past(cnt_q) - 1'b1))
    else $error("divider step count out of sequence");

  a_div_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_DIV) |-> (job_q.dist_sq != '0 && !job_q.lone))
    else $error("divider running on a zero or lone job");

  a_zero_force : assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> (out_q.zero_distance == (out_q.dist_squared == '0 && !out_q.no_neighbour)))
    else $error("zero distance flag disagrees with the distance");

endmodule

`default_nettype wire

// ----- rtl/adjacent_particle_coulomb_force_unit.sv -----
// Top level of the adjacent particle Coulomb force unit.
//
//   port group      direction  handshake                 word
//   in_*            in         in_valid_i / in_stall_o   apcf_pkg::in_word_t
//   out_*           out        out_valid_o / out_stall_i apcf_pkg::out_word_t
//   cfg_*           in         cfg_we_i                  force constant, 48 bits
//
// The front end holds the first particle of a longer run; one with a predecessor
// passes the square, sum and push-held states; the last of a run adds push-last, and
// a lone particle takes push-lone; a full queue holds each push state. It queues no
// job for the first particle of a longer run, two for the last and one for any other.
// Results pass the 48-step radix-2 divider; lone and zero-distance ones skip it.
// Reset is asynchronous and needs no clearing pass; the force constant resets
// to 1.0. A stalled output holds its word while the divider works on the next job.
`default_nettype none

module adjacent_particle_coulomb_force_unit (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          in_valid_i,
  output logic                         in_stall_o,
  input  apcf_pkg::in_word_t           in_word_i,
  output logic                         out_valid_o,
  input  wire                          out_stall_i,
  output apcf_pkg::out_word_t          out_word_o,
  input  wire                          cfg_we_i,
  input  wire [apcf_pkg::FORCE_W-1:0]  cfg_wdata_i
);
  import apcf_pkg::*;

  logic [FORCE_W-1:0] force_constant_q;
  logic               push, pop;
  job_t               push_job, head_job;
  queue_stat_t        q_stat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      force_constant_q <= FORCE_RESET;
    end else if (cfg_we_i) begin
      force_constant_q <= cfg_wdata_i;
    end
  end

  apcf_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .q_stat_i   (q_stat),
    .push_o     (push),
    .job_o      (push_job)
  );

  apcf_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (push_job),
    .pop_i  (pop),
    .job_o  (head_job),
    .stat_o (q_stat)
  );

  apcf_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .force_constant_i (force_constant_q),
    .q_stat_i         (q_stat),
    .job_i            (head_job),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_word_o       (out_word_o)
  );

endmodule

`default_nettype wire

// ----- sim/adjacent_particle_coulomb_force_unit_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench of the adjacent particle Coulomb force unit.
module adjacent_particle_coulomb_force_unit_tb;

  import apcf_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic in_valid = 1'b0;
  logic in_stall;
  in_word_t in_word = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_word_t out_word;
  logic cfg_we = 1'b0;
  logic [FORCE_W-1:0] cfg_wdata = '0;

  // When set, neither side inserts gaps or stalls.
  logic calm = 1'b0;
  int unsigned errors = 0;

  in_word_t particle_queue[$];
  out_word_t expected_forces[$];

  // Predictor state.
  logic [FORCE_W-1:0] force_k = FORCE_RESET;
  logic signed [COORD_WIDTH-1:0] held_x = '0;
  logic signed [COORD_WIDTH-1:0] held_y = '0;
  logic [SUM_W:0] held_back_dist = '0;
  logic [1:0] run_seen = '0;
  logic [INDEX_W-1:0] held_idx = '0;

  adjacent_particle_coulomb_force_unit DUT (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid),
    .in_stall_o(in_stall),
    .in_word_i(in_word),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_word_o(out_word),
    .cfg_we_i(cfg_we),
    .cfg_wdata_i(cfg_wdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [SUM_W:0] span_sq(logic signed [COORD_WIDTH-1:0] ax,
                                             logic signed [COORD_WIDTH-1:0] ay,
                                             logic signed [COORD_WIDTH-1:0] bx,
                                             logic signed [COORD_WIDTH-1:0] by);
    longint dx;
    longint dy;
    dx = longint'(ax) - longint'(bx);
    dy = longint'(ay) - longint'(by);
    return (SUM_W + 1)'(dx * dx + dy * dy);
  endfunction

  function automatic out_word_t pair_force(logic [INDEX_W-1:0] idx, logic take_next,
                                           logic [SUM_W:0] d, logic last);
    out_word_t w;
    logic [63:0] q;
    w = '0;
    w.particle_index = idx;
    w.neighbour_is_next = take_next;
    w.dist_squared = d[DIST_W-1:0];
    w.last_result = last;
    if (d == '0) begin
      w.force_res = '1;
      w.zero_distance = 1'b1;
    end else begin
      q = 64'(force_k) / 64'(d);
      w.force_res = q[FORCE_W-1:0];
    end
    return w;
  endfunction

  function automatic void predict_forces(in_word_t p);
    logic [SUM_W:0] fwd;
    logic take_next;
    out_word_t w;
    if (run_seen == 2'd0) begin
      if (p.last_in_run) begin
        w = '0;
        w.no_neighbour = 1'b1;
        w.last_result = 1'b1;
        expected_forces.push_back(w);
      end else begin
        held_x = p.pos_x;
        held_y = p.pos_y;
        held_idx = '0;
        run_seen = 2'd1;
      end
    end else begin
      fwd = span_sq(held_x, held_y, p.pos_x, p.pos_y);
      take_next = (run_seen == 2'd1) ? 1'b1 : !(held_back_dist < fwd);
      expected_forces.push_back(pair_force(held_idx, take_next,
                                           take_next ? fwd : held_back_dist, 1'b0));
      if (p.last_in_run) begin
        expected_forces.push_back(pair_force(held_idx + 1'b1, 1'b0, fwd, 1'b1));
        held_x = '0;
        held_y = '0;
        held_back_dist = '0;
        held_idx = '0;
        run_seen = 2'd0;
      end else begin
        held_x = p.pos_x;
        held_y = p.pos_y;
        held_back_dist = fwd;
        held_idx = held_idx + 1'b1;
        run_seen = 2'd2;
      end
    end
  endfunction

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) begin
        predict_forces(in_word);
      end
      if (particle_queue.size() != 0 && (calm || $urandom_range(99) >= 29)) begin
        in_valid <= 1'b1;
        in_word <= particle_queue.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin : watch
    out_word_t want;
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_forces.size() == 0) begin
          $error("unexpected result word, index %0d", out_word.particle_index);
          errors++;
        end else begin
          want = expected_forces.pop_front();
          if (out_word.particle_index !== want.particle_index) begin
            $error("particle_index expected %0d got %0d",
                   want.particle_index, out_word.particle_index);
            errors++;
          end
          if (out_word.neighbour_is_next !== want.neighbour_is_next) begin
            $error("neighbour_is_next expected %0d got %0d",
                   want.neighbour_is_next, out_word.neighbour_is_next);
            errors++;
          end
          if (out_word.dist_squared !== want.dist_squared) begin
            $error("dist_squared expected %0d got %0d",
                   want.dist_squared, out_word.dist_squared);
            errors++;
          end
          if (out_word.force_res !== want.force_res) begin
            $error("force_res expected %0h got %0h", want.force_res, out_word.force_res);
            errors++;
          end
          if (out_word.zero_distance !== want.zero_distance) begin
            $error("zero_distance expected %0d got %0d",
                   want.zero_distance, out_word.zero_distance);
            errors++;
          end
          if (out_word.no_neighbour !== want.no_neighbour) begin
            $error("no_neighbour expected %0d got %0d",
                   want.no_neighbour, out_word.no_neighbour);
            errors++;
          end
          if (out_word.last_result !== want.last_result) begin
            $error("last_result expected %0d got %0d",
                   want.last_result, out_word.last_result);
            errors++;
          end
        end
      end
      out_stall <= !calm && ($urandom_range(99) < 29);
    end
  end

  task automatic push_particle(logic [15:0] x, logic [15:0] y, logic last);
    in_word_t p;
    p.pos_x = x;
    p.pos_y = y;
    p.last_in_run = last;
    particle_queue.push_back(p);
  endtask

  // Clustered runs give ties and coincident neighbours; scattered ones cover the full range.
  task automatic queue_run(int unsigned len, logic clustered);
    logic [15:0] bx;
    logic [15:0] by;
    bx = 16'($urandom);
    by = 16'($urandom);
    for (int unsigned k = 0; k < len; k++) begin
      if (clustered) begin
        push_particle(bx + 16'($urandom_range(6)) - 16'd3,
                      by + 16'($urandom_range(6)) - 16'd3, k == len - 1);
      end else begin
        push_particle(16'($urandom), 16'($urandom), k == len - 1);
      end
    end
  endtask

  task automatic random_batch(int unsigned budget);
    int unsigned queued;
    int unsigned len;
    queued = 0;
    while (queued < budget) begin
      case ($urandom_range(9))
        0: len = 1;
        1: len = $urandom_range(13, 60);
        default: len = $urandom_range(2, 12);
      endcase
      queue_run(len, 1'($urandom_range(1)));
      queued += len;
    end
  endtask

  task automatic drain();
    do begin
      @(negedge clk_i);
    end while (in_valid || particle_queue.size() != 0 || expected_forces.size() != 0);
    repeat (100) @(posedge clk_i);
  endtask

  task automatic set_force_constant(logic [FORCE_W-1:0] k);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= k;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    force_k = k;
  endtask

  initial begin : stimulus
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    push_particle(16'h8000, 16'h7fff, 1'b1);
    push_particle(16'h8000, 16'h8000, 1'b0);
    push_particle(16'h7fff, 16'h7fff, 1'b1);
    push_particle(16'd5, 16'd5, 1'b0);
    push_particle(16'd5, 16'd5, 1'b1);
    push_particle(16'd0, 16'd0, 1'b0);
    push_particle(16'd1, 16'd0, 1'b0);
    push_particle(16'd2, 16'd0, 1'b1);
    push_particle(16'd0, 16'd0, 1'b0);
    push_particle(16'd10, 16'd0, 1'b0);
    push_particle(16'd11, 16'd0, 1'b0);
    push_particle(16'd30, 16'd0, 1'b1);
    push_particle(16'hffff, 16'h0000, 1'b0);
    push_particle(16'h0000, 16'hffff, 1'b0);
    push_particle(16'h0000, 16'hffff, 1'b0);
    push_particle(16'hffff, 16'h0001, 1'b1);
    push_particle(16'h7fff, 16'h8000, 1'b1);

    set_force_constant('1);
    random_batch(300);
    set_force_constant('0);
    random_batch(250);
    set_force_constant(48'd1);
    calm = 1'b1;
    random_batch(250);
    drain();
    calm = 1'b0;
    set_force_constant(48'({$urandom, $urandom}));
    random_batch(300);
    set_force_constant(48'($urandom) << 12);
    random_batch(250);
    set_force_constant(48'd65536);
    random_batch(250);
    drain();

    if (errors == 0) begin
      $display("adjacent_particle_coulomb_force_unit_tb OK");
    end else begin
      $display("adjacent_particle_coulomb_force_unit_tb NOT OK");
    end
    $finish;
  end

  initial begin : watchdog
    #50_000_000;
    $display("adjacent_particle_coulomb_force_unit_tb NOT OK");
    $finish;
  end

endmodule
